@@ src/plai_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the posting list AND intersection core.
// No dependencies; imported by plai_scan, the top level and the testbench.
package plai_pkg;

	localparam int MAX_LISTS   = 8;
	localparam int LIST_DEPTH  = 1024;

	localparam int DOC_W       = 31;
	localparam int TERM_W      = 4;
	localparam int LIDX_W      = 3;
	localparam int LIST_W      = $clog2(MAX_LISTS);
	localparam int TC_W        = $clog2(MAX_LISTS + 1);
	localparam int FILL_W      = $clog2(LIST_DEPTH + 1);
	localparam int STORE_DEPTH = (MAX_LISTS - 1) * LIST_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int PADDR_W     = 2;
	localparam int PDATA_W     = 32;

	localparam logic               CMD_APPEND     = 1'b0;
	localparam logic               CMD_PROBE      = 1'b1;
	localparam logic [PADDR_W-1:0] REG_TERM_COUNT = 2'd0;
	localparam logic [TERM_W-1:0]  TERM_COUNT_RST = 4'd1;

	typedef struct packed {
		logic              cmd;
		logic [LIDX_W-1:0] list_index;
		logic [DOC_W-1:0]  doc_id;
		logic              last_probe;
	} in_t;

	typedef struct packed {
		logic [DOC_W-1:0] result_doc;
		logic             matched;
		logic             last;
	} out_t;

	// Request from the scan controller to the list store.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DOC_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

@@ src/plai_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module plai_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/plai_scan.sv @@
`timescale 1ns / 1ps
// Append/probe controller: fill counts, list scan sequencer and result register.
// Depends on plai_pkg; drives the list store held in plai_ram.
module plai_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  plai_pkg::in_t              item,
	input  logic [plai_pkg::TERM_W-1:0] term_count,
	output logic                       busy,
	output logic                       result_valid,
	output plai_pkg::out_t             result,
	output plai_pkg::ram_req_t         ram_req,
	input  logic [plai_pkg::DOC_W-1:0] rd_data
);
	import plai_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic              state_q;
	logic [LIST_W-1:0] list_q;
	logic [FILL_W-1:0] idx_q;
	logic              rd_v_s1;
	logic [DOC_W-1:0]  id_q;
	logic              last_q;
	logic [TC_W-1:0]   tc_q;
	logic              out_valid_q;
	out_t              out_q;
	logic [FILL_W-1:0] fill_q [MAX_LISTS];

	logic [LIST_W-1:0] fill_sel;
	logic [FILL_W-1:0] fill_rd;
	logic              list_ok;
	logic              append_ok;
	logic              probe_go;
	logic [TC_W-1:0]   tc_eff;
	logic              issuing;
	logic              hit_s1;
	logic              list_done;
	logic [TC_W-1:0]   next_list;
	logic              finish;
	logic              fill_any;

	assign busy = (state_q == ST_SCAN);

	always_comb begin
		fill_sel  = busy ? list_q : LIST_W'(item.list_index);
		fill_rd   = fill_q[fill_sel];
		list_ok   = (item.list_index != '0) && (32'(item.list_index) < MAX_LISTS);
		append_ok = start && !busy && (item.cmd == CMD_APPEND) && list_ok
			&& (fill_rd < FILL_W'(LIST_DEPTH));
		probe_go  = start && !busy && (item.cmd == CMD_PROBE);
		tc_eff    = (32'(term_count) > MAX_LISTS) ? TC_W'(MAX_LISTS) : TC_W'(term_count);
		issuing   = busy && (idx_q < fill_rd);
		hit_s1    = rd_v_s1 && (rd_data == id_q);
		// a list resolves on a hit, or once every entry has been read back
		list_done = busy && (hit_s1 || !issuing);
		next_list = TC_W'(list_q) + TC_W'(1);
		finish    = list_done && (!hit_s1 || (next_list >= tc_q));
	end

	always_comb begin
		ram_req.we    = append_ok;
		ram_req.waddr = ADDR_W'(fill_sel - LIST_W'(1)) * ADDR_W'(LIST_DEPTH)
			+ ADDR_W'(fill_rd);
		ram_req.wdata = item.doc_id;
		ram_req.re    = issuing;
		ram_req.raddr = ADDR_W'(list_q - LIST_W'(1)) * ADDR_W'(LIST_DEPTH)
			+ ADDR_W'(idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			list_q      <= '0;
			idx_q       <= '0;
			rd_v_s1     <= 1'b0;
			tc_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_LISTS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			out_valid_q <= 1'b0;
			if (append_ok) begin
				fill_q[fill_sel] <= fill_rd + FILL_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (probe_go) begin
						tc_q <= tc_eff;
						if (tc_eff <= TC_W'(1)) begin
							// nothing to scan: answer straight away
							out_valid_q <= 1'b1;
							if (item.last_probe) begin
								for (int i = 0; i < MAX_LISTS; i++) begin
									fill_q[i] <= '0;
								end
							end
						end else begin
							state_q <= ST_SCAN;
							list_q  <= LIST_W'(1);
							idx_q   <= '0;
							rd_v_s1 <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (finish) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						rd_v_s1     <= 1'b0;
						if (last_q) begin
							for (int i = 0; i < MAX_LISTS; i++) begin
								fill_q[i] <= '0;
							end
						end
					end else if (list_done) begin
						// hit: drop the read in flight and move to the next list
						list_q  <= list_q + LIST_W'(1);
						idx_q   <= '0;
						rd_v_s1 <= 1'b0;
					end else begin
						rd_v_s1 <= issuing;
						if (issuing) begin
							idx_q <= idx_q + FILL_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (probe_go) begin
			id_q       <= item.doc_id;
			last_q     <= item.last_probe;
			out_q      <= '{result_doc: item.doc_id, matched: (tc_eff != '0),
				last: item.last_probe};
		end else if (finish) begin
			out_q      <= '{result_doc: id_q, matched: hit_s1, last: last_q};
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		fill_any = 1'b0;
		for (int i = 0; i < MAX_LISTS; i++) begin
			fill_any = fill_any | (fill_q[i] != '0);
		end
	end

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == ST_IDLE))
		else $error("result word given while a scan is running");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == ST_SCAN))
		else $error("read data pending outside a scan");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> !fill_any)
		else $error("list counts not cleared after final probe");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (idx_q <= fill_rd))
		else $error("scan index ran past list fill");

endmodule

@@ src/posting_list_and_intersect_core.sv @@
`timescale 1ns / 1ps
// Posting list AND intersection core: top level with APB register port.
// Depends on plai_pkg, plai_scan and plai_ram.
//
// Usage:
//   A word is accepted on a rising edge with start high and busy low.
//   cmd = append stores doc_id at the end of list list_index (1..7); it
//   gives no result, and is dropped when the list is full.
//   cmd = probe checks doc_id against lists 1..term_count-1 and gives one
//   result word, valid for exactly one cycle on result_valid.
//   With term_count of 0 or 1 the result is registered and follows in the cycle after the probe.
//   Otherwise busy is high while the lists are scanned, one list store read
//   per cycle from the single read port; a list ends on a hit, and an id
//   absent from a list ends the scan. No new word is taken while busy.
//   A probe with last_probe set empties all lists as its result is given.
//   term_count is written through the APB port at address 0; the user must
//   write it only while idle, which the block does not enforce.
//   Reset empties all lists and sets term_count to 1; the store itself is
//   not cleared. The receiver cannot stall: result words are not held.
module posting_list_and_intersect_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  plai_pkg::in_t                 item,
	output logic                          busy,
	output logic                          result_valid,
	output plai_pkg::out_t                result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plai_pkg::PADDR_W-1:0]  paddr,
	input  logic [plai_pkg::PDATA_W-1:0]  pwdata,
	output logic [plai_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import plai_pkg::*;

	logic [TERM_W-1:0] term_q;
	ram_req_t          ram_req;
	logic [DOC_W-1:0]  rd_data;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERM_COUNT_RST;
		end else if (psel && penable && pwrite && pready && (paddr == REG_TERM_COUNT)) begin
			term_q <= pwdata[TERM_W-1:0];
		end
	end

	assign prdata = (paddr == REG_TERM_COUNT) ? PDATA_W'(term_q) : '0;

	plai_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.term_count   (term_q),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result),
		.ram_req      (ram_req),
		.rd_data      (rd_data)
	);

	plai_ram #(
		.WIDTH (DOC_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rd_data)
	);

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench for posting_list_and_intersect_core: directed and random list loads and probes,
// every result word checked against an in-bench model of the intersection.
// Depends on plai_pkg and the core RTL.
module tb;
	import plai_pkg::*;

	localparam longint TIMEOUT_NS = 64'd8_000_000;
	localparam int     SETTLE     = 6;
	localparam int     RANDOM_WORDS = 580;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	in_t                  item;
	logic                 busy;
	logic                 result_valid;
	out_t                 result;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	posting_list_and_intersect_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.item        (item),
		.busy        (busy),
		.result_valid(result_valid),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// model of the stored lists and the term count
	logic [DOC_W-1:0]  posting_mem [1:MAX_LISTS-1][0:LIST_DEPTH-1];
	int                posting_fill [0:MAX_LISTS-1];
	logic [TERM_W-1:0] tc_reg;

	out_t pending_results[$];
	int   error_count;
	int   words_sent;
	int   burst_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

	function automatic void flag_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	function automatic logic doc_in_every_list(input logic [DOC_W-1:0] id);
		int  tc;
		logic hit;
		tc = (tc_reg > MAX_LISTS) ? MAX_LISTS : tc_reg;
		if (tc == 0)
			return 1'b0;
		for (int t = 1; t < tc; t++) begin
			hit = 1'b0;
			for (int j = 0; j < posting_fill[t]; j++)
				if (posting_mem[t][j] == id)
					hit = 1'b1;
			if (!hit)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic apply_word(input in_t w);
		int   li;
		out_t r;
		li = w.list_index;
		if (w.cmd == CMD_APPEND) begin
			if (li >= 1 && li < MAX_LISTS && posting_fill[li] < LIST_DEPTH) begin
				posting_mem[li][posting_fill[li]] = w.doc_id;
				posting_fill[li]++;
			end
		end else begin
			r.result_doc = w.doc_id;
			r.matched    = doc_in_every_list(w.doc_id);
			r.last       = w.last_probe;
			pending_results.push_back(r);
			if (w.last_probe)
				foreach (posting_fill[k])
					posting_fill[k] = 0;
		end
	endtask

	// start stays high after acceptance; pace() or go_idle() lowers it
	task automatic send_word(input in_t w);
		start <= 1'b1;
		item  <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_word(w);
		if (!(w.cmd == CMD_APPEND && w.list_index == 0))
			words_sent++;
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic append_doc(input int li, input logic [DOC_W-1:0] id, input logic lp);
		in_t w;
		w.cmd        = CMD_APPEND;
		w.list_index = LIDX_W'(li);
		w.doc_id     = id;
		w.last_probe = lp;
		send_word(w);
	endtask

	task automatic probe_doc(input logic [DOC_W-1:0] id, input logic lp);
		in_t w;
		w.cmd        = CMD_PROBE;
		w.list_index = LIDX_W'($urandom);
		w.doc_id     = id;
		w.last_probe = lp;
		send_word(w);
	endtask

	// appends give no result word, so also let the core settle after the last one
	task automatic go_idle();
		start <= 1'b0;
		@(posedge clk);
		while (busy || pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_term_count(input logic [PDATA_W-1:0] v);
		go_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_TERM_COUNT;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tc_reg = v[TERM_W-1:0];
		// read back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[TERM_W-1:0] !== tc_reg)
			flag_error($sformatf("term_count readback exp %0d got %0d",
				tc_reg, prdata[TERM_W-1:0]));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		out_t want;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected result word doc=%h matched=%b last=%b",
					result.result_doc, result.matched, result.last));
			end else begin
				want = pending_results.pop_front();
				if (result.result_doc !== want.result_doc || result.matched !== want.matched ||
						result.last !== want.last)
					flag_error($sformatf("doc exp %h got %h, matched exp %b got %b, last exp %b got %b",
						want.result_doc, result.result_doc, want.matched, result.matched,
						want.last, result.last));
			end
		end
	end

	// term_count 1 after reset: nothing to check, every probe matches
	task automatic test_reset_state();
		append_doc(0, 31'h1234_5678, 1'b0);
		append_doc(1, 31'h0000_0001, 1'b1);
		probe_doc('0, 1'b0);
		probe_doc('1, 1'b0);
		probe_doc(31'h2AAA_AAAA, 1'b1);
	endtask

	task automatic test_term_count_zero();
		write_term_count(32'hFFFF_FFF0);
		probe_doc('0, 1'b0);
		probe_doc(31'h5555_5555, 1'b1);
	endtask

	task automatic test_two_lists();
		write_term_count(32'd3);
		append_doc(1, '0, 1'b0);
		append_doc(1, '1, 1'b0);
		append_doc(1, 31'd5, 1'b0);
		append_doc(1, 31'd5, 1'b0);
		append_doc(2, 31'd5, 1'b1);
		append_doc(2, '1, 1'b0);
		append_doc(2, 31'd9, 1'b0);
		probe_doc(31'd5, 1'b0);
		probe_doc('1, 1'b0);
		probe_doc('0, 1'b0);
		probe_doc(31'd9, 1'b0);
		probe_doc(31'd5, 1'b1);
		// lists are empty again
		probe_doc(31'd5, 1'b1);
	endtask

	// counts above the list count clamp, so list 7 is still checked
	task automatic test_all_lists();
		logic [DOC_W-1:0] a, b;
		a = DOC_W'($urandom);
		b = a ^ 31'h4000_0001;
		write_term_count(32'd15);
		for (int l = 1; l < MAX_LISTS; l++) begin
			append_doc(l, a, 1'b0);
			if (l < MAX_LISTS - 1)
				append_doc(l, b, 1'b0);
		end
		probe_doc(a, 1'b0);
		probe_doc(b, 1'b0);
		write_term_count(32'h5A5A_0009);
		probe_doc(a, 1'b1);
	endtask

	task automatic test_full_list();
		logic [DOC_W-1:0] base;
		base = DOC_W'($urandom);
		write_term_count(32'd2);
		for (int i = 0; i < LIST_DEPTH; i++) begin
			append_doc(1, DOC_W'(base + i), 1'b0);
			pace();
		end
		// dropped: list 1 is full
		for (int i = 0; i < 3; i++)
			append_doc(1, DOC_W'(base + LIST_DEPTH + i), 1'b0);
		probe_doc(DOC_W'(base + LIST_DEPTH - 1), 1'b0);
		probe_doc(DOC_W'(base + LIST_DEPTH), 1'b0);
		probe_doc(base, 1'b0);
		probe_doc(DOC_W'(base + LIST_DEPTH + 1), 1'b1);
	endtask

	task automatic run_random_query();
		logic [DOC_W-1:0] pool [6];
		int   tc, lists, n, np, deepest;
		in_t  w;
		tc = (tc_reg > MAX_LISTS) ? MAX_LISTS : tc_reg;
		lists = (tc > 1) ? tc - 1 : $urandom_range(0, 2);
		foreach (pool[k])
			pool[k] = DOC_W'($urandom);
		deepest = 0;
		foreach (posting_fill[k])
			if (posting_fill[k] > deepest)
				deepest = posting_fill[k];
		if (deepest > 40) begin
			probe_doc(pool[0], 1'b1);
			pace();
		end
		for (int l = 1; l <= lists; l++) begin
			n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
			for (int k = 0; k < n; k++) begin
				w.cmd        = CMD_APPEND;
				w.list_index = LIDX_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 7) : l);
				w.doc_id     = ($urandom_range(0, 3) == 0) ? DOC_W'($urandom)
					: pool[$urandom_range(0, 5)];
				w.last_probe = 1'($urandom_range(0, 1));
				send_word(w);
				pace();
			end
		end
		np = $urandom_range(1, 8);
		for (int k = 0; k < np; k++) begin
			w.cmd        = CMD_PROBE;
			w.list_index = LIDX_W'($urandom);
			w.doc_id     = ($urandom_range(0, 3) == 0) ? DOC_W'($urandom)
				: pool[$urandom_range(0, 5)];
			w.last_probe = (k == np - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
			send_word(w);
			pace();
		end
	endtask

	task automatic test_random_queries();
		int               target, r;
		logic [PDATA_W-1:0] v;
		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			r = $urandom_range(0, 15);
			if (r < 10)
				v = $urandom_range(2, MAX_LISTS);
			else if (r == 10)
				v = 0;
			else if (r == 11)
				v = 1;
			else
				v = $urandom_range(MAX_LISTS + 1, 15);
			if ($urandom_range(0, 3) == 0)
				v = v | ($urandom & ~32'hF);
			write_term_count(v);
			repeat ($urandom_range(2, 5)) run_random_query();
		end
	endtask

	initial begin
		arst_n  <= 1'b0;
		start   <= 1'b0;
		item    <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		error_count = 0;
		words_sent  = 0;
		burst_left  = 0;
		tc_reg      = TERM_COUNT_RST;
		foreach (posting_fill[k])
			posting_fill[k] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_term_count_zero();
		test_two_lists();
		test_all_lists();
		test_full_list();
		test_random_queries();

		go_idle();
		if (error_count == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
